[sv/modinv_pkg.sv]
// Shared constants, types and control structures for the modular inverse block.
`timescale 1ns / 1ps

package modinv_pkg;

    // Operand width of the Euclid datapath.
    localparam int WIDTH = 32;

    // Field widths on the stream ports.
    localparam int VALUE_W   = 32;
    localparam int MODULUS_W = 32;
    localparam int INVERSE_W = 32;
    localparam int S_DATA_W  = ((VALUE_W + MODULUS_W + 7) / 8) * 8;
    localparam int M_DATA_W  = ((INVERSE_W + 1 + 7) / 8) * 8;

    // Bound on Euclid steps and the counter that tracks them.
    localparam int ITER_MAX = 2 * WIDTH + 2;
    localparam int ITER_W   = $clog2(ITER_MAX + 1);

    // Bit counter of the shared divider.
    localparam int DCNT_W = $clog2(WIDTH);

    // Divider operand selection.
    typedef enum logic {
        DIV_SEL_REDUCE = 1'b0,  // value / modulus
        DIV_SEL_STEP   = 1'b1   // r0 / r1
    } div_sel_t;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_REDUCE,
        ST_RINIT,
        ST_CHECK,
        ST_DIV,
        ST_MUL,
        ST_UPD,
        ST_FIN
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load;
        logic     div_start;
        div_sel_t div_sel;
        logic     init_r1;
        logic     mul;
        logic     update;
        logic     finish;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic m_zero;
        logic div_last;
        logic r1_zero;
        logic iter_max;
    } stat_t;

endpackage

[sv/modinv_div.sv]
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module modinv_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [modinv_pkg::WIDTH-1:0] dividend,
    input  logic [modinv_pkg::WIDTH-1:0] divisor,
    output logic                      last,
    output logic [modinv_pkg::WIDTH-1:0] quo,
    output logic [modinv_pkg::WIDTH-1:0] rem
);
    import modinv_pkg::*;

    logic              busy_reg, busy_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic [WIDTH-1:0]  rem_reg, rem_next;
    logic [WIDTH-1:0]  quo_reg, quo_next;
    logic [WIDTH-1:0]  dsr_reg, dsr_next;
    logic [WIDTH:0]    shifted;
    logic [WIDTH:0]    trial;

    // One trial subtraction of the divisor from the shifted remainder.
    assign shifted = {rem_reg, quo_reg[WIDTH-1]};
    assign trial   = shifted - {1'b0, dsr_reg};
    assign last    = busy_reg && (cnt_reg == '0);
    assign quo     = quo_reg;
    assign rem     = rem_reg;

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = DCNT_W'(WIDTH - 1);
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
            end
            if (!trial[WIDTH]) begin
                rem_next = trial[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b1};
            end else begin
                rem_next = shifted[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b0};
            end
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operand and result registers.
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

endmodule

[sv/modinv_dp.sv]
// Datapath: remainder and coefficient registers, shared divider, multiplier, result.
`timescale 1ns / 1ps

module modinv_dp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  modinv_pkg::cmd_t               cmd,
    output modinv_pkg::stat_t              stat,
    input  logic [modinv_pkg::VALUE_W-1:0]   in_value,
    input  logic [modinv_pkg::MODULUS_W-1:0] in_modulus,
    output logic [modinv_pkg::INVERSE_W-1:0] out_inverse,
    output logic                           out_exists
);
    import modinv_pkg::*;

    logic [WIDTH-1:0]     a_reg, m_reg;
    logic [WIDTH-1:0]     r0_reg, r1_reg;
    logic [WIDTH-1:0]     t0_reg, t1_reg;
    logic                 t0neg_reg, t1neg_reg;
    logic [WIDTH-1:0]     prod_reg;
    logic [ITER_W-1:0]    iter_reg;
    logic [INVERSE_W-1:0] inv_reg;
    logic                 exists_reg;

    logic [WIDTH-1:0]     div_dividend, div_divisor;
    logic [WIDTH-1:0]     div_quo, div_rem;
    logic                 div_last;
    logic [2*WIDTH-1:0]   prod_full;
    logic [WIDTH-1:0]     t0_red, inv_val;
    logic                 ok;

    // Divider operands: the initial reduction or one Euclid step.
    always_comb begin
        case (cmd.div_sel)
            DIV_SEL_REDUCE: begin
                div_dividend = a_reg;
                div_divisor  = m_reg;
            end
            DIV_SEL_STEP: begin
                div_dividend = r0_reg;
                div_divisor  = r1_reg;
            end
            default: begin
                div_dividend = r0_reg;
                div_divisor  = r1_reg;
            end
        endcase
    end

    modinv_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .last     (div_last),
        .quo      (div_quo),
        .rem      (div_rem)
    );

    // Quotient times coefficient; the true product never exceeds the modulus.
    assign prod_full = div_quo * t1_reg;

    // Coefficient brought into range and sign applied for the final result.
    assign t0_red  = (t0_reg >= m_reg) ? (t0_reg - m_reg) : t0_reg;
    assign inv_val = (t0neg_reg && (t0_red != '0)) ? (m_reg - t0_red) : t0_red;
    assign ok      = (m_reg != '0) && (r0_reg == WIDTH'(1));

    // Status toward the controller.
    assign stat.m_zero   = (m_reg == '0);
    assign stat.div_last = div_last;
    assign stat.r1_zero  = (r1_reg == '0);
    assign stat.iter_max = (iter_reg == ITER_W'(ITER_MAX));

    // Euclid state registers.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            a_reg <= WIDTH'(in_value);
            m_reg <= WIDTH'(in_modulus);
        end
        if (cmd.init_r1) begin
            r0_reg    <= m_reg;
            r1_reg    <= div_rem;
            t0_reg    <= '0;
            t0neg_reg <= 1'b0;
            t1_reg    <= WIDTH'(1);
            t1neg_reg <= 1'b0;
            iter_reg  <= '0;
        end else if (cmd.update) begin
            r0_reg    <= r1_reg;
            r1_reg    <= div_rem;
            t0_reg    <= t1_reg;
            t0neg_reg <= t1neg_reg;
            t1_reg    <= t0_reg + prod_reg;
            t1neg_reg <= ~t1neg_reg;
            iter_reg  <= iter_reg + 1'b1;
        end
        if (cmd.mul) begin
            prod_reg <= prod_full[WIDTH-1:0];
        end
        if (cmd.finish) begin
            inv_reg    <= ok ? INVERSE_W'(inv_val) : '0;
            exists_reg <= ok;
        end
    end

    assign out_inverse = inv_reg;
    assign out_exists  = exists_reg;

endmodule

[sv/modinv_ctrl.sv]
// Controller state machine that sequences the Euclid steps and the handshakes.
`timescale 1ns / 1ps

module modinv_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  modinv_pkg::stat_t stat,
    output modinv_pkg::cmd_t  cmd
);
    import modinv_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || m_tready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_START;
            end
            ST_START: begin
                state_next = stat.m_zero ? ST_FIN : ST_REDUCE;
            end
            ST_REDUCE: begin
                if (stat.div_last) state_next = ST_RINIT;
            end
            ST_RINIT: begin
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                state_next = (stat.r1_zero || stat.iter_max) ? ST_FIN : ST_DIV;
            end
            ST_DIV: begin
                if (stat.div_last) state_next = ST_MUL;
            end
            ST_MUL: begin
                state_next = ST_UPD;
            end
            ST_UPD: begin
                state_next = ST_CHECK;
            end
            ST_FIN: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands and handshake outputs.
    always_comb begin
        cmd         = '0;
        cmd.div_sel = DIV_SEL_REDUCE;
        s_tready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_START: begin
                cmd.div_start = !stat.m_zero;
            end
            ST_RINIT: begin
                cmd.init_r1 = 1'b1;
            end
            ST_CHECK: begin
                cmd.div_sel   = DIV_SEL_STEP;
                cmd.div_start = !(stat.r1_zero || stat.iter_max);
            end
            ST_DIV: begin
                cmd.div_sel = DIV_SEL_STEP;
            end
            ST_MUL: begin
                // The quotient register holds its final value from this cycle on.
                cmd.mul = 1'b1;
            end
            ST_UPD: begin
                cmd.update = 1'b1;
            end
            ST_FIN: begin
                cmd.finish = out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    // The result register is full from finish until the request is taken.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (m_tready) out_valid_next = 1'b0;
        if (cmd.finish) out_valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

[sv/modular_inverse_top.sv]
// Top level of the modular inverse block (extended Euclid on a shared divider).
//
//  channel | direction | tdata fields (low bit first)            | tuser/tlast
//  s_      | in        | value[31:0], modulus[63:32]              | none
//  m_      | out       | inverse[31:0], exists[32], zero[39:33]   | none
//
// A request goes from acceptance to the result register through one reduction
// of the value by the modulus, then k Euclid steps (at most about 46 for
// 32-bit operands, capped at ITER_MAX); the bit-serial divider gives one
// quotient bit a cycle. A zero modulus skips all division.
// Synchronous reset on aresetn clears the controller, divider busy and output valid.
// A new request is taken while the previous result still waits on m_tready;
// a stalled output holds the finished item until the register frees up.
`timescale 1ns / 1ps

module modular_inverse_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [modinv_pkg::S_DATA_W-1:0]   s_tdata,   // value, modulus
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [modinv_pkg::M_DATA_W-1:0]   m_tdata    // inverse, exists, zero pad
);
    import modinv_pkg::*;

    cmd_t                 cmd;
    stat_t                stat;
    logic [INVERSE_W-1:0] out_inverse;
    logic                 out_exists;

    modinv_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    modinv_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .in_value    (s_tdata[VALUE_W-1:0]),
        .in_modulus  (s_tdata[VALUE_W+MODULUS_W-1:VALUE_W]),
        .out_inverse (out_inverse),
        .out_exists  (out_exists)
    );

    // Pack the result fields, padded with zeros to whole bytes.
    assign m_tdata = {{(M_DATA_W - INVERSE_W - 1){1'b0}}, out_exists, out_inverse};

endmodule
